@@ hw/rtl/ctb_pkg.sv @@
// Package for the countdown timer bank: sizes, opcodes, register indexes,
// sequencer states and the timer memory request type.
// No dependencies; every other file of the block uses it.
`default_nettype none

package ctb_pkg;

   // Bank size and timer width.
   localparam int NUM_TIMERS = 8;
   localparam int TIMER_BITS = 16;

   // Field widths of the items.
   localparam int OPCODE_BITS = 2;
   localparam int INDEX_BITS  = 3;
   localparam int LOAD_BITS   = 16;
   localparam int COUNT_BITS  = 16;

   // Configuration port.
   localparam int CSR_INDEX_BITS = 1;
   localparam int CSR_DATA_BITS  = 16;
   localparam int TPM_BITS       = 8;
   localparam int MPS_BITS       = 16;
   localparam logic [TPM_BITS-1:0] TPM_RESET = 8'd8;
   localparam logic [MPS_BITS-1:0] MPS_RESET = 16'd1000;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_TICKS_PER_MS  = 1'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MS_PER_SECOND = 1'd1;

   // Timer memory addressing and the sweep counter, which must hold NUM_TIMERS.
   localparam int ADDR_BITS = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
   localparam int WALK_BITS = $clog2(NUM_TIMERS + 1);

   // Opcodes; the fourth code does nothing.
   localparam logic [OPCODE_BITS-1:0] OP_TICK  = 2'd0;
   localparam logic [OPCODE_BITS-1:0] OP_START = 2'd1;
   localparam logic [OPCODE_BITS-1:0] OP_QUERY = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_QWAIT,
      ST_WALK,
      ST_DONE
   } ctb_state_type;

   typedef struct packed {
      logic                  rd_en;
      logic [ADDR_BITS-1:0]  rd_addr;
      logic                  wr_en;
      logic [ADDR_BITS-1:0]  wr_addr;
      logic [TIMER_BITS-1:0] wr_data;
   } ctb_mem_req_type;

   function automatic logic index_in_range(input logic [INDEX_BITS-1:0] idx);
      return (32'(idx) < NUM_TIMERS);
   endfunction

endpackage

`default_nettype wire

@@ hw/rtl/ctb_req_if.sv @@
// Request channel of the countdown timer bank: valid/ready plus one item.
// Depends on ctb_pkg for the field widths.
`default_nettype none

interface ctb_req_if;
   logic                             valid;
   logic                             ready;
   logic [ctb_pkg::OPCODE_BITS-1:0]  opcode;
   logic [ctb_pkg::INDEX_BITS-1:0]   timer_index;
   logic [ctb_pkg::LOAD_BITS-1:0]    load_value;

   modport source (output valid, opcode, timer_index, load_value, input ready);
   modport sink   (input valid, opcode, timer_index, load_value, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/ctb_rsp_if.sv @@
// Result channel of the countdown timer bank: valid/ready plus one result item.
// Depends on ctb_pkg for the field widths.
`default_nettype none

interface ctb_rsp_if;
   logic                            valid;
   logic                            ready;
   logic                            expired;
   logic                            ms_strobe;
   logic [ctb_pkg::COUNT_BITS-1:0]  time_ms;
   logic [ctb_pkg::COUNT_BITS-1:0]  time_s;

   modport source (output valid, expired, ms_strobe, time_ms, time_s, input ready);
   modport sink   (input valid, expired, ms_strobe, time_ms, time_s, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/ctb_timer_mem.sv @@
// Timer value memory: one write port, one registered read port, and a valid
// bit per entry so that entries never written since reset read as zero.
// Depends on ctb_pkg.
`default_nettype none

module ctb_timer_mem (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire ctb_pkg::ctb_mem_req_type        mem_req,
   output      logic [ctb_pkg::TIMER_BITS-1:0]  rd_data
);

   logic [ctb_pkg::TIMER_BITS-1:0] mem_q [ctb_pkg::NUM_TIMERS];
   logic [ctb_pkg::NUM_TIMERS-1:0] valid_ff;
   logic [ctb_pkg::TIMER_BITS-1:0] rd_data_ff;
   logic                           rd_hit_ff;

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         mem_q[mem_req.wr_addr] <= mem_req.wr_data;
      end
      if (mem_req.rd_en) begin
         rd_data_ff <= mem_q[mem_req.rd_addr];
         rd_hit_ff  <= valid_ff[mem_req.rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (mem_req.wr_en) begin
         valid_ff[mem_req.wr_addr] <= 1'b1;
      end
   end

   assign rd_data = rd_hit_ff ? rd_data_ff : '0;

   // The sequencer never reads an entry in the cycle it writes it.
   assert property (@(posedge clock) disable iff (reset)
      !(mem_req.rd_en && mem_req.wr_en && mem_req.rd_addr == mem_req.wr_addr))
      else $error("timer memory read and write collide on one entry");

endmodule

`default_nettype wire

@@ hw/rtl/ctb_ctrl.sv @@
// Sequencer of the countdown timer bank: configuration registers, time
// counters, the read-modify-write sweep over the timer memory and the
// result register. Depends on ctb_pkg, ctb_req_if and ctb_rsp_if.
`default_nettype none

module ctb_ctrl (
   input  wire logic                                clock,
   input  wire logic                                reset,
   ctb_req_if.sink                                  req_ch,
   ctb_rsp_if.source                                rsp_ch,
   input  wire logic                                csr_we,
   input  wire logic [ctb_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  wire logic [ctb_pkg::CSR_DATA_BITS-1:0]   csr_wdata,
   output      ctb_pkg::ctb_mem_req_type            mem_req,
   input  wire logic [ctb_pkg::TIMER_BITS-1:0]      rd_data
);

   ctb_pkg::ctb_state_type state_ff, state_in;

   logic [ctb_pkg::OPCODE_BITS-1:0] op_ff;
   logic [ctb_pkg::INDEX_BITS-1:0]  idx_ff;
   logic [ctb_pkg::LOAD_BITS-1:0]   load_ff;

   logic [ctb_pkg::TPM_BITS-1:0]    tpm_ff;
   logic [ctb_pkg::MPS_BITS-1:0]    mps_ff;
   logic [7:0]                      tick_pre_ff, tick_pre_in;
   logic [15:0]                     ms_pre_ff, ms_pre_in;
   logic [ctb_pkg::COUNT_BITS-1:0]  ms_cnt_ff, sec_cnt_ff;

   logic [ctb_pkg::WALK_BITS-1:0]   walk_cnt_ff;
   logic                            wb_pend_ff;
   logic [ctb_pkg::ADDR_BITS-1:0]   wb_addr_ff;

   logic                            res_expired_ff, res_strobe_ff;
   logic                            rsp_valid_ff, rsp_expired_ff, rsp_strobe_ff;
   logic [ctb_pkg::COUNT_BITS-1:0]  rsp_ms_ff, rsp_s_ff;

   logic                            accept, idx_valid, out_free, walk_done;
   logic                            ms_step, sec_step, walk_issue, load_rsp;
   logic [7:0]                      tick_pre_inc, div_t;
   logic [15:0]                     ms_pre_inc, div_s;
   logic [ctb_pkg::TIMER_BITS-1:0]  dec_value;

   // Prescalers: a zero divider acts as one, and a prescaler that sits at or
   // above a lowered divider completes its step on the next advance.
   always_comb begin
      div_t        = (tpm_ff == '0) ? 8'd1 : tpm_ff;
      div_s        = (mps_ff == '0) ? 16'd1 : mps_ff;
      tick_pre_inc = tick_pre_ff + 8'd1;
      ms_pre_inc   = ms_pre_ff + 16'd1;
      ms_step      = (tick_pre_inc >= div_t) || (tick_pre_inc == '0);
      sec_step     = (ms_pre_inc >= div_s) || (ms_pre_inc == '0);
      tick_pre_in  = ms_step ? '0 : tick_pre_inc;
      ms_pre_in    = sec_step ? '0 : ms_pre_inc;
   end

   assign accept    = req_ch.valid && req_ch.ready;
   assign idx_valid = ctb_pkg::index_in_range(idx_ff);
   assign out_free  = !rsp_valid_ff || rsp_ch.ready;
   assign walk_done = (walk_cnt_ff == ctb_pkg::WALK_BITS'(ctb_pkg::NUM_TIMERS));
   assign dec_value = (rd_data == '0) ? '0 : rd_data - ctb_pkg::TIMER_BITS'(1);

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ctb_pkg::ST_IDLE: begin
            if (accept) state_in = ctb_pkg::ST_EXEC;
         end
         ctb_pkg::ST_EXEC: begin
            unique case (op_ff)
               ctb_pkg::OP_TICK:  state_in = ms_step ? ctb_pkg::ST_WALK : ctb_pkg::ST_DONE;
               ctb_pkg::OP_QUERY: state_in = idx_valid ? ctb_pkg::ST_QWAIT : ctb_pkg::ST_DONE;
               default:           state_in = ctb_pkg::ST_DONE;
            endcase
         end
         ctb_pkg::ST_QWAIT: state_in = ctb_pkg::ST_DONE;
         ctb_pkg::ST_WALK: begin
            if (walk_done && !wb_pend_ff) state_in = ctb_pkg::ST_DONE;
         end
         ctb_pkg::ST_DONE: begin
            if (out_free) state_in = ctb_pkg::ST_IDLE;
         end
         default: state_in = ctb_pkg::ST_IDLE;
      endcase
   end

   // Outputs of the sequencer.
   always_comb begin
      req_ch.ready = 1'b0;
      mem_req      = '0;
      walk_issue   = 1'b0;
      load_rsp     = 1'b0;
      unique case (state_ff)
         ctb_pkg::ST_IDLE: req_ch.ready = 1'b1;
         ctb_pkg::ST_EXEC: begin
            if (op_ff == ctb_pkg::OP_START && idx_valid) begin
               mem_req.wr_en   = 1'b1;
               mem_req.wr_addr = ctb_pkg::ADDR_BITS'(idx_ff);
               mem_req.wr_data = ctb_pkg::TIMER_BITS'(load_ff);
            end
            if (op_ff == ctb_pkg::OP_QUERY && idx_valid) begin
               mem_req.rd_en   = 1'b1;
               mem_req.rd_addr = ctb_pkg::ADDR_BITS'(idx_ff);
            end
         end
         ctb_pkg::ST_WALK: begin
            // Reads run one entry ahead of the write-back of the previous one.
            walk_issue      = !walk_done;
            mem_req.rd_en   = !walk_done;
            mem_req.rd_addr = walk_cnt_ff[ctb_pkg::ADDR_BITS-1:0];
            mem_req.wr_en   = wb_pend_ff;
            mem_req.wr_addr = wb_addr_ff;
            mem_req.wr_data = dec_value;
         end
         ctb_pkg::ST_DONE: load_rsp = out_free;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ctb_pkg::ST_IDLE;
         tpm_ff       <= ctb_pkg::TPM_RESET;
         mps_ff       <= ctb_pkg::MPS_RESET;
         tick_pre_ff  <= '0;
         ms_pre_ff    <= '0;
         ms_cnt_ff    <= '0;
         sec_cnt_ff   <= '0;
         walk_cnt_ff  <= '0;
         wb_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_we) begin
            unique case (csr_index)
               ctb_pkg::CSR_TICKS_PER_MS:  tpm_ff <= csr_wdata[ctb_pkg::TPM_BITS-1:0];
               ctb_pkg::CSR_MS_PER_SECOND: mps_ff <= csr_wdata[ctb_pkg::MPS_BITS-1:0];
               default: ;
            endcase
         end
         if (state_ff == ctb_pkg::ST_EXEC && op_ff == ctb_pkg::OP_TICK) begin
            tick_pre_ff <= tick_pre_in;
            if (ms_step) begin
               ms_cnt_ff <= ms_cnt_ff + ctb_pkg::COUNT_BITS'(1);
               ms_pre_ff <= ms_pre_in;
               if (sec_step) sec_cnt_ff <= sec_cnt_ff + ctb_pkg::COUNT_BITS'(1);
            end
         end
         if (state_ff == ctb_pkg::ST_EXEC) begin
            walk_cnt_ff <= '0;
         end else if (walk_issue) begin
            walk_cnt_ff <= walk_cnt_ff + ctb_pkg::WALK_BITS'(1);
         end
         wb_pend_ff <= walk_issue;
         if (load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff   <= req_ch.opcode;
         idx_ff  <= req_ch.timer_index;
         load_ff <= req_ch.load_value;
      end
      if (walk_issue) wb_addr_ff <= walk_cnt_ff[ctb_pkg::ADDR_BITS-1:0];
      if (state_ff == ctb_pkg::ST_EXEC) begin
         res_strobe_ff  <= (op_ff == ctb_pkg::OP_TICK) && ms_step;
         res_expired_ff <= (op_ff == ctb_pkg::OP_QUERY) && !idx_valid;
      end else if (state_ff == ctb_pkg::ST_QWAIT) begin
         res_expired_ff <= (rd_data == '0);
      end
      if (load_rsp) begin
         rsp_expired_ff <= res_expired_ff;
         rsp_strobe_ff  <= res_strobe_ff;
         rsp_ms_ff      <= ms_cnt_ff;
         rsp_s_ff       <= sec_cnt_ff;
      end
   end

   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.expired   = rsp_expired_ff;
   assign rsp_ch.ms_strobe = rsp_strobe_ff;
   assign rsp_ch.time_ms   = rsp_ms_ff;
   assign rsp_ch.time_s    = rsp_s_ff;

   assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == ctb_pkg::ST_EXEC)
      else $error("accepted item did not start execution");

   assert property (@(posedge clock) disable iff (reset)
      state_ff == ctb_pkg::ST_IDLE |-> !mem_req.wr_en && !mem_req.rd_en)
      else $error("timer memory accessed while idle");

   assert property (@(posedge clock) disable iff (reset)
      32'(walk_cnt_ff) <= ctb_pkg::NUM_TIMERS)
      else $error("sweep counter ran past the last timer");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_strobe_ff && rsp_expired_ff))
      else $error("result marks both a millisecond step and an expiry");

endmodule

`default_nettype wire

@@ hw/rtl/countdown_timer_bank.sv @@
// Countdown timer bank: one item at a time, taken only while the sequencer is idle.
// An accepted item runs in EXEC, where a start writes its timer and a query reads it;
// a query then waits in QWAIT, and a tick with a millisecond step sweeps all timers
// in WALK, reading each one while the one before is written back, then ends in DONE.
// The next item is taken as a result is offered; a held one stalls DONE until taken.
// Synchronous active-high reset: timers and counters zero, ticks_per_ms 8, ms_per_second 1000.
`default_nettype none

module countdown_timer_bank (
   input  wire logic                                clock,
   input  wire logic                                reset,
   ctb_req_if.sink                                  req_ch,
   ctb_rsp_if.source                                rsp_ch,
   input  wire logic                                csr_we,
   input  wire logic [ctb_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  wire logic [ctb_pkg::CSR_DATA_BITS-1:0]   csr_wdata
);

   ctb_pkg::ctb_mem_req_type        mem_req;
   logic [ctb_pkg::TIMER_BITS-1:0]  rd_data;

   ctb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .mem_req   (mem_req),
      .rd_data   (rd_data)
   );

   ctb_timer_mem u_mem (
      .clock   (clock),
      .reset   (reset),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

endmodule

`default_nettype wire
